// ===== hdl/cht_pkg.sv =====
// shared types and constants of the chained hash table
`timescale 1ns / 1ps

package cht_pkg;

  localparam int KEY_W     = 31;
  localparam int STAT_W    = 2;
  localparam int BKT_W     = 4;
  localparam int POS_W     = 4;
  localparam int TS_W      = 5;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;
  localparam int DVD_W     = 32;
  localparam int DIV_STEPS = DVD_W / 2;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  localparam logic [TS_W-1:0] TS_RESET = TS_W'(11);

  // register index inside the configuration space
  localparam logic REG_TABLE_SIZE = 1'b0;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_FOUND    = 2'd1,
    ST_MISSING  = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

endpackage

// ===== hdl/cht_in_if.sv =====
// request channel of the chained hash table
`timescale 1ns / 1ps

interface cht_in_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [cht_pkg::KEY_W-1:0] key;

  modport source (output valid, cmd, key, input ready);
  modport sink   (input valid, cmd, key, output ready);
endinterface

// ===== hdl/cht_out_if.sv =====
// result channel of the chained hash table
`timescale 1ns / 1ps

interface cht_out_if;
  logic                      valid;
  logic                      ready;
  cht_pkg::status_t          status;
  logic [cht_pkg::BKT_W-1:0] bucket;
  logic [cht_pkg::POS_W-1:0] position;

  modport source (output valid, status, bucket, position, input ready);
  modport sink   (input valid, status, bucket, position, output ready);
endinterface

// ===== hdl/chained_hash_table.sv =====
// chained hash table: top level with sequencer, divider and bucket walk
// Usage: each request on in_ch carries cmd (insert or search-and-remove)
// and a 31-bit key. The bucket is key modulo table_size (0 acts as 1,
// values above MAX_BUCKETS saturate). Every request gives exactly one
// result on out_ch: status, bucket and 1-based position.
// One request is worked on at a time. The remainder comes from a radix-4
// restoring divider, followed by a read of the bucket fill count from its
// ram and, for a search, a walk over the bucket that reads one entry per
// cycle and writes the later entries one place down behind the match.
// Results sit in an output register; a new request is taken while a
// result waits, and a finished result waits in the sequencer while the
// receiver stalls and the output register is still full.
// After reset (rst_n low, synchronous) the fill ram is cleared, one
// bucket per cycle, with in_ch.ready low. table_size resets to 11 and
// is written over the APB port at byte address 0.
`timescale 1ns / 1ps

module chained_hash_table #(
  parameter int MAX_BUCKETS  = 16,
  parameter int BUCKET_DEPTH = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  cht_in_if.sink                      in_ch,
  cht_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [cht_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [cht_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [cht_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int BKT_IW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int DEP_IW    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int FILL_W    = $clog2(BUCKET_DEPTH + 1);
  localparam int ENT_DEPTH = MAX_BUCKETS * BUCKET_DEPTH;
  localparam int ENT_AW    = (ENT_DEPTH > 1) ? $clog2(ENT_DEPTH) : 1;
  localparam int TS_W      = cht_pkg::TS_W;
  localparam int KEY_W     = cht_pkg::KEY_W;

  localparam logic [FILL_W-1:0] FULL_CNT = FILL_W'(BUCKET_DEPTH);
  localparam logic [BKT_IW-1:0] LAST_BKT = BKT_IW'(MAX_BUCKETS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_FILL_RD,
    S_DECIDE,
    S_WALK,
    S_RESP
  } state_t;

  state_t                       state_r, state_nxt;
  logic [TS_W-1:0]              table_size_r;
  logic [TS_W-1:0]              eff_size;
  logic [TS_W-1:0]              div_r, div_nxt;
  logic [TS_W-1:0]              rem_r, rem_nxt;
  logic [cht_pkg::DVD_W-1:0]    dvd_r, dvd_nxt;
  logic [cht_pkg::DIV_CW-1:0]   div_cnt_r, div_cnt_nxt;
  logic [BKT_IW-1:0]            clr_cnt_r, clr_cnt_nxt;
  logic                         cmd_r, cmd_nxt;
  logic [KEY_W-1:0]             key_r, key_nxt;
  logic [BKT_IW-1:0]            bkt_r, bkt_nxt;
  logic [FILL_W-1:0]            fill_r, fill_nxt;
  logic [FILL_W-1:0]            rd_i_r, rd_i_nxt;
  logic [DEP_IW-1:0]            cmp_i_r, cmp_i_nxt;
  logic                         cmp_vld_r, cmp_vld_nxt;
  logic                         found_r, found_nxt;
  logic [DEP_IW-1:0]            hit_i_r, hit_i_nxt;
  cht_pkg::status_t             res_status_r, res_status_nxt;
  logic [FILL_W-1:0]            res_pos_r, res_pos_nxt;
  logic                         out_valid_r, out_valid_nxt;
  cht_pkg::status_t             out_status_r, out_status_nxt;
  logic [cht_pkg::BKT_W-1:0]    out_bucket_r, out_bucket_nxt;
  logic [cht_pkg::POS_W-1:0]    out_pos_r, out_pos_nxt;

  logic                         fill_we;
  logic [BKT_IW-1:0]            fill_waddr;
  logic [FILL_W-1:0]            fill_wdata;
  logic [BKT_IW-1:0]            fill_raddr;
  logic [FILL_W-1:0]            fill_rdata;
  logic                         ent_we;
  logic [ENT_AW-1:0]            ent_waddr;
  logic [KEY_W-1:0]             ent_wdata;
  logic [ENT_AW-1:0]            ent_raddr;
  logic [KEY_W-1:0]             ent_rdata;

  logic                         in_acc;
  logic                         out_free;
  logic                         cfg_wr;
  logic                         cmp_hit;
  logic                         cmp_last;

  // one restoring step of the remainder
  function automatic logic [TS_W-1:0] rem_step(input logic [TS_W-1:0] rem,
                                               input logic            dbit,
                                               input logic [TS_W-1:0] d);
    logic [TS_W:0] t;
    t = {rem, dbit};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[TS_W-1:0];
  endfunction

  function automatic logic [ENT_AW-1:0] ent_addr(input logic [BKT_IW-1:0] b,
                                                 input logic [DEP_IW-1:0] idx);
    return ENT_AW'(int'(b) * BUCKET_DEPTH + int'(idx));
  endfunction

  cht_ram #(
    .WIDTH (FILL_W),
    .DEPTH (MAX_BUCKETS)
  ) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .raddr (fill_raddr),
    .rdata (fill_rdata)
  );

  cht_ram #(
    .WIDTH (KEY_W),
    .DEPTH (ENT_DEPTH)
  ) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == cht_pkg::REG_TABLE_SIZE) ?
                      cht_pkg::CFG_DW'(table_size_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= cht_pkg::TS_RESET;
    end else if (cfg_wr && cfg_paddr[2] == cht_pkg::REG_TABLE_SIZE) begin
      table_size_r <= cfg_pwdata[TS_W-1:0];
    end
  end

  always_comb begin
    if (table_size_r == '0) begin
      eff_size = TS_W'(1);
    end else if (int'(table_size_r) > MAX_BUCKETS) begin
      eff_size = TS_W'(MAX_BUCKETS);
    end else begin
      eff_size = table_size_r;
    end
  end

  assign in_ch.ready     = (state_r == S_IDLE);
  assign in_acc          = in_ch.valid && in_ch.ready;
  assign out_free        = !out_valid_r || out_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.bucket   = out_bucket_r;
  assign out_ch.position = out_pos_r;

  assign cmp_hit  = (ent_rdata == key_r);
  assign cmp_last = (FILL_W'(cmp_i_r) == fill_r - FILL_W'(1));

  always_comb begin
    state_nxt      = state_r;
    div_nxt        = div_r;
    rem_nxt        = rem_r;
    dvd_nxt        = dvd_r;
    div_cnt_nxt    = div_cnt_r;
    clr_cnt_nxt    = clr_cnt_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    bkt_nxt        = bkt_r;
    fill_nxt       = fill_r;
    rd_i_nxt       = rd_i_r;
    cmp_i_nxt      = cmp_i_r;
    cmp_vld_nxt    = 1'b0;
    found_nxt      = found_r;
    hit_i_nxt      = hit_i_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_bucket_nxt = out_bucket_r;
    out_pos_nxt    = out_pos_r;

    fill_we    = 1'b0;
    fill_waddr = bkt_r;
    fill_wdata = '0;
    fill_raddr = bkt_r;
    ent_we     = 1'b0;
    ent_waddr  = ent_addr(bkt_r, '0);
    ent_wdata  = key_r;
    ent_raddr  = ent_addr(bkt_r, rd_i_r[DEP_IW-1:0]);

    unique case (state_r)
      S_CLEAR: begin
        fill_we     = 1'b1;
        fill_waddr  = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + BKT_IW'(1);
        if (clr_cnt_r == LAST_BKT) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt     = in_ch.cmd;
          key_nxt     = in_ch.key;
          dvd_nxt     = {1'b0, in_ch.key};
          div_nxt     = eff_size;
          rem_nxt     = '0;
          div_cnt_nxt = '0;
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        // two quotient bits per cycle
        rem_nxt     = rem_step(rem_step(rem_r, dvd_r[cht_pkg::DVD_W-1], div_r),
                               dvd_r[cht_pkg::DVD_W-2], div_r);
        dvd_nxt     = {dvd_r[cht_pkg::DVD_W-3:0], 2'b00};
        div_cnt_nxt = div_cnt_r + cht_pkg::DIV_CW'(1);
        if (div_cnt_r == cht_pkg::DIV_CW'(cht_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_FILL_RD;
        end
      end
      S_FILL_RD: begin
        // remainder is below the divisor, which never exceeds MAX_BUCKETS
        bkt_nxt    = BKT_IW'(rem_r);
        fill_raddr = BKT_IW'(rem_r);
        state_nxt  = S_DECIDE;
      end
      S_DECIDE: begin
        fill_nxt    = fill_rdata;
        rd_i_nxt    = '0;
        found_nxt   = 1'b0;
        res_pos_nxt = '0;
        state_nxt   = S_RESP;
        if (cmd_r == cht_pkg::CMD_INSERT) begin
          if (fill_rdata >= FULL_CNT) begin
            res_status_nxt = cht_pkg::ST_FULL;
          end else begin
            ent_we         = 1'b1;
            ent_waddr      = ent_addr(bkt_r, fill_rdata[DEP_IW-1:0]);
            fill_we        = 1'b1;
            fill_wdata     = fill_rdata + FILL_W'(1);
            res_status_nxt = cht_pkg::ST_INSERTED;
            res_pos_nxt    = fill_rdata + FILL_W'(1);
          end
        end else if (fill_rdata == '0) begin
          res_status_nxt = cht_pkg::ST_MISSING;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        // read one entry per cycle, compare it in the next cycle
        if (rd_i_r < fill_r) begin
          cmp_i_nxt   = rd_i_r[DEP_IW-1:0];
          cmp_vld_nxt = 1'b1;
          rd_i_nxt    = rd_i_r + FILL_W'(1);
        end
        if (cmp_vld_r) begin
          if (found_r) begin
            // close the gap behind the removed key
            ent_we    = 1'b1;
            ent_waddr = ent_addr(bkt_r, cmp_i_r - DEP_IW'(1));
            ent_wdata = ent_rdata;
          end else if (cmp_hit) begin
            found_nxt = 1'b1;
            hit_i_nxt = cmp_i_r;
          end
          if (cmp_last) begin
            state_nxt = S_RESP;
            if (found_r || cmp_hit) begin
              fill_we        = 1'b1;
              fill_wdata     = fill_r - FILL_W'(1);
              res_status_nxt = cht_pkg::ST_FOUND;
              res_pos_nxt    = FILL_W'(found_r ? hit_i_r : cmp_i_r) + FILL_W'(1);
            end else begin
              res_status_nxt = cht_pkg::ST_MISSING;
              res_pos_nxt    = '0;
            end
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_bucket_nxt = cht_pkg::BKT_W'(bkt_r);
          out_pos_nxt    = cht_pkg::POS_W'(res_pos_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      div_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      div_cnt_r   <= div_cnt_nxt;
    end
    div_r        <= div_nxt;
    rem_r        <= rem_nxt;
    dvd_r        <= dvd_nxt;
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    bkt_r        <= bkt_nxt;
    fill_r       <= fill_nxt;
    rd_i_r       <= rd_i_nxt;
    cmp_i_r      <= cmp_i_nxt;
    hit_i_r      <= hit_i_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    out_status_r <= out_status_nxt;
    out_bucket_r <= out_bucket_nxt;
    out_pos_r    <= out_pos_nxt;
  end

  // a bucket count never goes past the bucket depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_we |-> (fill_wdata <= FULL_CNT))
    else $error("bucket fill count above depth");

  // entries move down only after the match has been seen
  a_shift_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (ent_we && state_r == S_WALK) |-> found_r)
    else $error("entry shifted before a match");

  // remainder is reduced below the divisor before the bucket is used
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL_RD) |-> (rem_r < div_r))
    else $error("remainder not below divisor");

  // a finished result waits while the output register is held
  a_resp_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && out_valid_r && !out_ch.ready) |=>
    (state_r == S_RESP && out_valid_r))
    else $error("result lost while receiver stalls");

endmodule

// ===== hdl/cht_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sim/tb_chained_hash_table.sv =====
// self-checking testbench of the chained hash table
`timescale 1ns / 1ps

module tb_chained_hash_table;

  localparam int TABLE_BUCKETS = 16;
  localparam int CHAIN_DEPTH   = 8;
  localparam int REG_UNUSED    = 1;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 92;

  typedef struct packed {
    cht_pkg::status_t          status;
    logic [cht_pkg::BKT_W-1:0] bucket;
    logic [cht_pkg::POS_W-1:0] position;
  } result_t;

  typedef enum logic [1:0] {ROW_REQ, ROW_CFG, ROW_CFG_SPARE} row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic                      cmd;
    logic [cht_pkg::KEY_W-1:0] key;    // register value on configuration rows
    logic                      typed;
    result_t                   want;
  } row_t;

  localparam result_t NO_RESULT = '{cht_pkg::ST_INSERTED, 4'd0, 4'd0};

  // bucket 3 under size 11 holds 3, 14, 25, ... until it is full
  row_t directed_rows [28] = '{
    '{ROW_REQ, cht_pkg::CMD_INSERT, 31'd0, 1'b1, '{cht_pkg::ST_INSERTED, 4'd0, 4'd1}},
    '{ROW_REQ, cht_pkg::CMD_SEARCH, 31'd5, 1'b1, '{cht_pkg::ST_MISSING, 4'd5, 4'd0}},
    '{ROW_REQ, cht_pkg::CMD_INSERT, 31'h7FFF_FFFF, 1'b0, NO_RESULT},
    '{ROW_REQ, cht_pkg::CMD_INSERT, 31'd11, 1'b0, NO_RESULT},
    '{ROW_REQ, cht_pkg::CMD_INSERT, 31'd0, 1'b0, NO_RESULT},
    '{ROW_REQ, cht_pkg::CMD_SEARCH, 31'd0, 1'b1, '{cht_pkg::ST_FOUND, 4'd0, 4'd1}},
    '{ROW_REQ, cht_pkg::CMD_SEARCH, 31'd0, 1'b0, NO_RESULT},
    '{ROW_REQ, cht_pkg::CMD_SEARCH, 31'd0, 1'b0, NO_RESULT},
    '{ROW_REQ, cht_pkg::CMD_INSERT, 31'd3, 1'b0, NO_RESULT},
    '{ROW_REQ, cht_pkg::CMD_INSERT, 31'd14, 1'b0, NO_RESULT},
    '{ROW_REQ, cht_pkg::CMD_INSERT, 31'd25, 1'b0, NO_RESULT},
    '{ROW_REQ, cht_pkg::CMD_INSERT, 31'd36, 1'b0, NO_RESULT},
    '{ROW_REQ, cht_pkg::CMD_INSERT, 31'd47, 1'b0, NO_RESULT},
    '{ROW_REQ, cht_pkg::CMD_INSERT, 31'd58, 1'b0, NO_RESULT},
    '{ROW_REQ, cht_pkg::CMD_INSERT, 31'd69, 1'b0, NO_RESULT},
    '{ROW_REQ, cht_pkg::CMD_INSERT, 31'd80, 1'b0, NO_RESULT},
    '{ROW_REQ, cht_pkg::CMD_INSERT, 31'd91, 1'b1, '{cht_pkg::ST_FULL, 4'd3, 4'd0}},
    '{ROW_REQ, cht_pkg::CMD_SEARCH, 31'd25, 1'b0, NO_RESULT},
    '{ROW_REQ, cht_pkg::CMD_SEARCH, 31'h7FFF_FFFF, 1'b0, NO_RESULT},
    '{ROW_CFG, cht_pkg::CMD_INSERT, 31'd0, 1'b0, NO_RESULT},
    '{ROW_REQ, cht_pkg::CMD_SEARCH, 31'd14, 1'b0, NO_RESULT},
    '{ROW_REQ, cht_pkg::CMD_INSERT, 31'd12345, 1'b0, NO_RESULT},
    '{ROW_CFG, cht_pkg::CMD_INSERT, 31'd31, 1'b0, NO_RESULT},
    '{ROW_REQ, cht_pkg::CMD_INSERT, 31'h7FFF_FFFF, 1'b0, NO_RESULT},
    '{ROW_CFG_SPARE, cht_pkg::CMD_INSERT, 31'd5, 1'b0, NO_RESULT},
    '{ROW_REQ, cht_pkg::CMD_INSERT, 31'd16, 1'b0, NO_RESULT},
    '{ROW_CFG, cht_pkg::CMD_INSERT, 31'd16, 1'b0, NO_RESULT},
    '{ROW_REQ, cht_pkg::CMD_SEARCH, 31'd3, 1'b0, NO_RESULT}
  };

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_psel;
  logic                       cfg_penable;
  logic                       cfg_pwrite;
  logic [cht_pkg::CFG_AW-1:0] cfg_paddr;
  logic [cht_pkg::CFG_DW-1:0] cfg_pwdata;
  logic [cht_pkg::CFG_DW-1:0] cfg_prdata;
  logic                       cfg_pready;

  cht_in_if  in_if ();
  cht_out_if out_if ();

  chained_hash_table #(
    .MAX_BUCKETS  (TABLE_BUCKETS),
    .BUCKET_DEPTH (CHAIN_DEPTH)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // shadow of the table contents and of the size register
  logic [cht_pkg::TS_W-1:0]  size_shadow = cht_pkg::TS_RESET;
  logic [cht_pkg::KEY_W-1:0] chain_keys [TABLE_BUCKETS][CHAIN_DEPTH];
  int unsigned               chain_fill [TABLE_BUCKETS] = '{default: 0};

  result_t     pending_results [$];
  result_t     oldest;
  int          mismatches   = 0;
  int          idle_mode    = 0;  // 0 none, 1 sender, 2 receiver, 3 both lightly
  bit          hold_pending = 1'b0;
  int unsigned hold_left    = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic result_t apply_to_table(logic cmd, logic [cht_pkg::KEY_W-1:0] key);
    int unsigned divisor;
    int unsigned b;
    int unsigned n;
    int          hit;
    result_t     r;
    divisor = (size_shadow == 0) ? 1 :
              (size_shadow > TABLE_BUCKETS) ? TABLE_BUCKETS : size_shadow;
    b = key % divisor;
    n = chain_fill[b];
    hit = -1;
    r.bucket = cht_pkg::BKT_W'(b);
    r.position = '0;
    if (cmd == cht_pkg::CMD_INSERT) begin
      if (n >= CHAIN_DEPTH) begin
        r.status = cht_pkg::ST_FULL;
      end else begin
        chain_keys[b][n] = key;
        chain_fill[b] = n + 1;
        r.status = cht_pkg::ST_INSERTED;
        r.position = cht_pkg::POS_W'(n + 1);
      end
    end else begin
      r.status = cht_pkg::ST_MISSING;
      for (int i = 0; i < n; i++) begin
        if (hit < 0 && chain_keys[b][i] == key) hit = i;
      end
      if (hit >= 0) begin
        // close the gap, keeping insertion order
        for (int k = hit; k + 1 < n; k++) chain_keys[b][k] = chain_keys[b][k + 1];
        chain_fill[b] = n - 1;
        r.status = cht_pkg::ST_FOUND;
        r.position = cht_pkg::POS_W'(hit + 1);
      end
    end
    return r;
  endfunction

  function automatic logic [cht_pkg::KEY_W-1:0] random_key();
    logic [cht_pkg::KEY_W-1:0] k;
    case ($urandom_range(0, 3))
      0: k = cht_pkg::KEY_W'($urandom);
      1: k = cht_pkg::KEY_W'($urandom_range(0, 63));
      2: k = cht_pkg::KEY_W'(31'h7FFF_FFFF - $urandom_range(0, 15));
      default: k = cht_pkg::KEY_W'($urandom_range(0, 63) * 16 + $urandom_range(0, 3));
    endcase
    return k;
  endfunction

  function automatic bit sender_rests();
    case (idle_mode)
      1: return $urandom_range(0, 99) < 67;
      3: return $urandom_range(0, 99) < 12;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_request(input logic cmd, input logic [cht_pkg::KEY_W-1:0] key,
                              input bit typed, input result_t typed_result);
    result_t predicted;
    while (sender_rests()) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.cmd   <= cmd;
    in_if.key   <= key;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predicted = apply_to_table(cmd, key);
    pending_results.insert(pending_results.size(), typed ? typed_result : predicted);
    @(negedge clk);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_register(input int unsigned idx,
                                  input logic [cht_pkg::CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= cht_pkg::CFG_AW'(4 * idx);
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (idx == cht_pkg::REG_TABLE_SIZE) size_shadow = value[cht_pkg::TS_W-1:0];
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx == cht_pkg::REG_TABLE_SIZE) begin
      @(negedge clk);
      cfg_psel   <= 1'b1;
      cfg_pwrite <= 1'b0;
      @(negedge clk);
      cfg_penable <= 1'b1;
      @(posedge clk);
      while (!cfg_pready) @(posedge clk);
      if (cfg_prdata !== cht_pkg::CFG_DW'(size_shadow)) begin
        $display("%0t: table_size readback mismatch, expected %0d actual %0h",
                 $time, size_shadow, cfg_prdata);
        mismatches++;
      end
      @(negedge clk);
      cfg_psel    <= 1'b0;
      cfg_penable <= 1'b0;
    end
  endtask

  // receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (hold_pending) begin
      hold_pending = 1'b0;
      hold_left <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else begin
      case (idle_mode)
        2: out_if.ready <= $urandom_range(0, 99) >= 67;
        3: out_if.ready <= $urandom_range(0, 99) >= 12;
        default: out_if.ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %0d/%0d/%0d", $time,
                 out_if.status, out_if.bucket, out_if.position);
        mismatches++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("status", oldest.status, out_if.status);
        check_field("bucket", oldest.bucket, out_if.bucket);
        check_field("position", oldest.position, out_if.position);
      end
    end
  end

  initial begin
    #(4_000_000);
    $display("chained_hash_table verification failed");
    $finish;
  end

  initial begin
    logic                      cmd;
    logic [cht_pkg::KEY_W-1:0] key;
    int unsigned               first;
    int unsigned               b;
    bit                        got;
    logic [cht_pkg::TS_W-1:0]  size_pick;
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.cmd    = cht_pkg::CMD_INSERT;
    in_if.key    = '0;
    out_if.ready = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[r]) begin
      case (directed_rows[r].kind)
        ROW_REQ: send_request(directed_rows[r].cmd, directed_rows[r].key,
                              directed_rows[r].typed, directed_rows[r].want);
        ROW_CFG: begin
          drain();
          program_register(cht_pkg::REG_TABLE_SIZE,
                           cht_pkg::CFG_DW'({$urandom,
                                             directed_rows[r].key[cht_pkg::TS_W-1:0]}));
        end
        default: begin
          drain();
          program_register(REG_UNUSED, cht_pkg::CFG_DW'(directed_rows[r].key));
        end
      endcase
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: size_pick = cht_pkg::TS_W'(1);
        1: size_pick = cht_pkg::TS_W'(TABLE_BUCKETS);
        2: size_pick = '0;
        3: size_pick = '1;
        default: size_pick = cht_pkg::TS_W'($urandom_range(0, 31));
      endcase
      program_register(cht_pkg::REG_TABLE_SIZE,
                       cht_pkg::CFG_DW'({$urandom, size_pick}));
      idle_mode = p % 4;
      // the block fills up behind a long receiver hold-off
      if (p == 4) hold_pending = 1'b1;
      repeat (PHASE_ITEMS) begin
        cmd = ($urandom_range(0, 99) < 55) ? cht_pkg::CMD_INSERT : cht_pkg::CMD_SEARCH;
        key = random_key();
        if (cmd == cht_pkg::CMD_SEARCH && $urandom_range(0, 99) < 65) begin
          first = $urandom_range(0, TABLE_BUCKETS - 1);
          got = 1'b0;
          for (int j = 0; j < TABLE_BUCKETS; j++) begin
            b = (first + j) % TABLE_BUCKETS;
            if (!got && chain_fill[b] != 0) begin
              key = chain_keys[b][$urandom_range(0, chain_fill[b] - 1)];
              got = 1'b1;
            end
          end
        end
        send_request(cmd, key, 1'b0, NO_RESULT);
      end
    end

    idle_mode = 0;
    drain();
    if (mismatches == 0) begin
      $display("chained_hash_table verification clean");
    end else begin
      $display("chained_hash_table verification failed");
    end
    $finish;
  end

endmodule
